FILE: design/plvbe_pkg.sv
// Shared types, constants and the variable-byte coding function for the posting list encoder.
package plvbe_pkg;

  // Entries gathered before a block is flushed (1 to 16).
  localparam int unsigned BLOCK_SIZE = 16;
  // The entry store always has room for the largest block.
  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned OFS_W = 48;
  localparam logic [CNT_W-1:0] BLOCK_FILL = CNT_W'(BLOCK_SIZE);

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DOC    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_TERM  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_DOC   = 2'd2,
    KIND_FREQ  = 2'd3
  } kind_e;

  typedef struct packed {
    op_e              op;
    logic [VAL_W-1:0] term_id;
    logic [VAL_W-1:0] doc_count;
    logic [VAL_W-1:0] doc_id;
    logic [VAL_W-1:0] frequency;
  } in_req_t;

  typedef struct packed {
    kind_e            kind;
    logic [2:0]       nbytes;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [7:0]       byte2;
    logic [7:0]       byte3;
    logic [7:0]       byte4;
    logic [OFS_W-1:0] byte_offset;
    logic             last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_TERM,
    ST_EMIT_COUNT,
    ST_PRIME,
    ST_EMIT_ID,
    ST_EMIT_FREQ
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  hdr_load;
    logic  doc_load;
    logic  emit;
    kind_e word_kind;
    logic  word_last;
    logic  idx_clr;
    logic  idx_adv;
    logic  fill_clr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
    logic flush_due;
    logic idx_at_end;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [2:0]      nbytes;
    logic [4:0][7:0] bytes;
  } vb_word_t;

  // Big-endian variable-byte code: 7-bit groups, most significant first,
  // continuation bit set on every byte but the last.
  function automatic vb_word_t vb_encode(logic [VAL_W-1:0] v);
    vb_word_t w;
    w.bytes = '0;
    if (|v[30:28]) begin
      w.nbytes   = 3'd5;
      w.bytes[0] = {1'b1, 4'b0, v[30:28]};
      w.bytes[1] = {1'b1, v[27:21]};
      w.bytes[2] = {1'b1, v[20:14]};
      w.bytes[3] = {1'b1, v[13:7]};
      w.bytes[4] = {1'b0, v[6:0]};
    end else if (|v[27:21]) begin
      w.nbytes   = 3'd4;
      w.bytes[0] = {1'b1, v[27:21]};
      w.bytes[1] = {1'b1, v[20:14]};
      w.bytes[2] = {1'b1, v[13:7]};
      w.bytes[3] = {1'b0, v[6:0]};
    end else if (|v[20:14]) begin
      w.nbytes   = 3'd3;
      w.bytes[0] = {1'b1, v[20:14]};
      w.bytes[1] = {1'b1, v[13:7]};
      w.bytes[2] = {1'b0, v[6:0]};
    end else if (|v[13:7]) begin
      w.nbytes   = 3'd2;
      w.bytes[0] = {1'b1, v[13:7]};
      w.bytes[1] = {1'b0, v[6:0]};
    end else begin
      w.nbytes   = 3'd1;
      w.bytes[0] = {1'b0, v[6:0]};
    end
    return w;
  endfunction

endpackage

FILE: design/plvbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plvbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/plvbe_ctrl.sv
// Controller state machine that sequences header words and block flushes.
module plvbe_ctrl import plvbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  op_e     in_op_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_HEADER) begin
            state_d = ST_EMIT_TERM;
          end else if (!status_i.rem_zero && status_i.flush_due) begin
            state_d = ST_PRIME;
          end
        end
      end
      ST_EMIT_TERM: begin
        if (status_i.out_free) state_d = ST_EMIT_COUNT;
      end
      ST_EMIT_COUNT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_PRIME: state_d = ST_EMIT_ID;
      ST_EMIT_ID: begin
        if (status_i.out_free && status_i.idx_at_end) state_d = ST_EMIT_FREQ;
      end
      ST_EMIT_FREQ: begin
        if (status_i.out_free && status_i.idx_at_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.hdr_load = accept && (in_op_i == OP_HEADER);
        cmd_o.doc_load = accept && (in_op_i == OP_DOC) && !status_i.rem_zero;
      end
      ST_EMIT_TERM: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.word_kind = KIND_TERM;
      end
      ST_EMIT_COUNT: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.word_kind = KIND_COUNT;
        cmd_o.word_last = 1'b1;
      end
      ST_PRIME: begin
        cmd_o.idx_clr = 1'b1;
      end
      ST_EMIT_ID: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.word_kind = KIND_DOC;
        cmd_o.idx_adv   = status_i.out_free;
      end
      ST_EMIT_FREQ: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.word_kind = KIND_FREQ;
        cmd_o.word_last = status_i.idx_at_end;
        cmd_o.idx_adv   = status_i.out_free;
        cmd_o.fill_clr  = status_i.out_free && status_i.idx_at_end;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A flush reaches its frequency pass only through the document id pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_FREQ) && !$past(state_q == ST_EMIT_FREQ)
    |-> $past(state_q == ST_EMIT_ID))
    else $error("frequency pass entered without id pass");

  // The read pointer is primed exactly once before each id pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRIME) |=> (state_q == ST_EMIT_ID))
    else $error("prime not followed by id pass");

endmodule

FILE: design/plvbe_dp.sv
// Datapath: list counters, entry store, coder, byte offset and output register.
module plvbe_dp import plvbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  cmd_t     cmd_i,
  output status_t  status_o,
  output logic     out_valid_o,
  output out_req_t out_req_o,
  input  logic     out_stall_i
);

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] term_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [OFS_W-1:0] bytes_q, bytes_d;
  logic             out_valid_q, out_valid_d;
  out_req_t         out_q, out_d;
  logic [CNT_W-1:0] fill_inc;
  logic [2*VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] word_val;
  vb_word_t         enc;
  logic [OFS_W-1:0] ofs_next;

  assign fill_inc = fill_q + CNT_W'(1);

  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.flush_due  = (fill_inc >= BLOCK_FILL) || (rem_q == VAL_W'(1));
  assign status_o.idx_at_end = ({1'b0, idx_q} == (fill_q - CNT_W'(1)));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // The read address follows the next index, so the registered read data always
  // holds the entry at the current index.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_adv) begin
      idx_d = status_o.idx_at_end ? '0 : idx_q + IDX_W'(1);
    end
  end

  plvbe_ram #(
    .WIDTH(2 * VAL_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.doc_load),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i ({in_req_i.doc_id, in_req_i.frequency}),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  always_comb begin
    fill_d = fill_q;
    rem_d  = rem_q;
    if (cmd_i.hdr_load) begin
      fill_d = '0;
      rem_d  = in_req_i.doc_count;
    end else if (cmd_i.doc_load) begin
      fill_d = fill_inc;
      rem_d  = rem_q - VAL_W'(1);
    end else if (cmd_i.fill_clr) begin
      fill_d = '0;
    end
  end

  // While the header words go out, the remaining count still equals the
  // announced count, so it doubles as the count word.
  always_comb begin
    case (cmd_i.word_kind)
      KIND_TERM:  word_val = term_q;
      KIND_COUNT: word_val = rem_q;
      KIND_DOC:   word_val = rd_data[2*VAL_W-1:VAL_W];
      default:    word_val = rd_data[VAL_W-1:0];
    endcase
  end

  assign enc      = vb_encode(word_val);
  assign ofs_next = bytes_q + OFS_W'(enc.nbytes);

  always_comb begin
    out_d             = out_q;
    bytes_d           = bytes_q;
    out_valid_d       = out_valid_q && out_stall_i;
    if (cmd_i.emit) begin
      out_valid_d       = 1'b1;
      bytes_d           = ofs_next;
      out_d.kind        = cmd_i.word_kind;
      out_d.nbytes      = enc.nbytes;
      out_d.byte0       = enc.bytes[0];
      out_d.byte1       = enc.bytes[1];
      out_d.byte2       = enc.bytes[2];
      out_d.byte3       = enc.bytes[3];
      out_d.byte4       = enc.bytes[4];
      out_d.byte_offset = ofs_next;
      out_d.last        = cmd_i.word_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      bytes_q     <= bytes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_load) begin
      term_q <= in_req_i.term_id;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // The buffer never holds more entries than one block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= BLOCK_FILL)
    else $error("entry buffer overfilled");

  // A new word is only loaded into a free or departing output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> status_o.out_free)
    else $error("output register overwritten");

  // Entries are only stored while the list still expects some.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.doc_load |-> (rem_q != '0))
    else $error("entry stored beyond announced count");

  // The running offset moves only when a word is emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.emit |=> $stable(bytes_q))
    else $error("byte offset changed without a word");

endmodule

FILE: design/posting_list_varbyte_block_encoder_top.sv
// Top level of the variable-byte posting list block encoder.
//
//   Channel  Direction  Handshake                     Payload
//   in       input      in_valid_i / in_stall_o       in_req_i  (in_req_t)
//   out      output     out_valid_o / out_stall_i     out_req_o (out_req_t)
//
// A header request is accepted while the controller is idle and then emits its
// term id and count words, each once the output register is free. A document
// request is stored while the list still expects entries; when it completes a
// block (or the list), the flush primes the entry store read port and then emits
// 2*n coded words for n buffered entries, each once the single output register is free.
// The input is stalled only while words of an earlier request are still being
// generated; a finished word may wait in the output register while the next
// request is accepted. Reset is asynchronous and active low and clears the
// counters, the byte offset and the state machine; the entry store needs no
// clearing because only entries written in the current block are read.
module posting_list_varbyte_block_encoder_top import plvbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  // Commands and status are the only link between the controller and the
  // datapath.
  cmd_t    cmd;
  status_t status;

  plvbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_req_i.op),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the list counters, the entry store, the coder and the
  // output register.
  plvbe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o),
    .out_stall_i (out_stall_i)
  );

endmodule
